// ----- src/fpa_pkg.sv -----
package fpa_pkg;

  // Widths of the data path.
  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;

  // The divider produces this many quotient bits, one per pipeline stage.
  // Any quotient at or above two to the power of DATA_W saturates, so one
  // spare bit is plenty.
  localparam int DIV_QBITS = DATA_W + 1;

  // Register stages inside the multiplier and the divider.
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = DIV_QBITS + 3;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_TOI  = 4'd8,
    OP_FRI  = 4'd9,
    OP_EQ   = 4'd10,
    OP_NE   = 4'd11,
    OP_LT   = 4'd12,
    OP_LE   = 4'd13,
    OP_GT   = 4'd14,
    OP_GE   = 4'd15
  } op_t;

  // Which unit supplies the final result of an item.
  typedef enum logic [1:0] {
    SEL_SIMPLE = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2
  } sel_t;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     compare_true;
    logic                     saturated;
    logic                     divide_by_zero;
  } out_item_t;

  // Result of the operations finished in the operand stage together with the unit select.
  typedef struct packed {
    sel_t      sel;
    out_item_t res;
  } pipe_t;

  // Operands of the divider, already reduced to magnitudes.
  typedef struct packed {
    logic [DATA_W-1:0] na;
    logic [DATA_W-1:0] nb;
    logic              neg;
    logic              a_neg;
    logic              dz;
  } div_in_t;

  // Sign and status bits that travel along the divider stages.
  typedef struct packed {
    logic neg;
    logic a_neg;
    logic dz;
    logic ovf;
  } div_ctl_t;

endpackage

// ----- src/fixed_point_alu_unit.sv -----
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
//
// Input channel: in_valid, in_stall and in_data carry an operation code and
// two raw operands. A transfer takes place on a rising edge at which
// in_valid is high and in_stall is low. Result channel: out_valid,
// out_stall and out_data return one result item for every input item, in
// the order in which the items arrived.
//
// Every operation takes the same path length. The depth is set by the
// divider, which decides one quotient bit per stage over 33 stages, plus
// set-up, rounding, clamp, the operand stage and the output register.
// Shorter operations ride along in delay lines. One item can be taken in
// every cycle unless a held output stall freezes the pipeline.
//
// Reset clears every valid bit, so the pipeline starts empty; the data
// registers are not reset. While out_valid is high and the receiver holds
// out_stall, the whole pipeline freezes and in_stall is raised, so nothing
// is lost or repeated; the pipeline moves on as soon as the stall drops.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fpa_pkg::out_item_t out_data
);

  localparam int DW = fpa_pkg::DATA_W;

  // The pipeline advances unless a finished result is held up at the output.
  logic adv;

  logic                 f_vld;
  fpa_pkg::pipe_t       f_pipe;
  logic signed [DW-1:0] f_a, f_b;
  fpa_pkg::div_in_t     f_div;

  fpa_pkg::out_item_t   m_res;
  fpa_pkg::out_item_t   dv_res;

  logic                 d1_vld, d2_vld;
  fpa_pkg::pipe_t       d1_pipe, d2_pipe, mg_pipe;

  logic                 out_valid_r, out_valid_nxt;
  fpa_pkg::out_item_t   out_data_r, out_data_nxt;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Operand stage: all operations other than multiply and divide are finished
  // here, and the operands are prepared for the multiplier and the divider.
  fpa_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_item (in_data),
    .vld_o   (f_vld),
    .pipe_o  (f_pipe),
    .a_o     (f_a),
    .b_o     (f_b),
    .div_o   (f_div)
  );

  fpa_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .en    (adv),
    .a_i   (f_a),
    .b_i   (f_b),
    .res_o (m_res)
  );

  fpa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .en    (adv),
    .div_i (f_div),
    .res_o (dv_res)
  );

  // The first delay line matches the multiplier; its output picks up the
  // product for multiply items before the second line matches the divider.
  fpa_delay #(
    .W     ($bits(fpa_pkg::pipe_t)),
    .DEPTH (fpa_pkg::MUL_LAT)
  ) u_dly_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (f_vld),
    .data_i (f_pipe),
    .vld_o  (d1_vld),
    .data_o (d1_pipe)
  );

  always_comb begin
    mg_pipe = d1_pipe;
    if (d1_pipe.sel == fpa_pkg::SEL_MUL) begin
      mg_pipe.res = m_res;
    end
  end

  fpa_delay #(
    .W     ($bits(fpa_pkg::pipe_t)),
    .DEPTH (fpa_pkg::DIV_LAT - fpa_pkg::MUL_LAT)
  ) u_dly_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (d1_vld),
    .data_i (mg_pipe),
    .vld_o  (d2_vld),
    .data_o (d2_pipe)
  );

  // Output register: the divider result is chosen for divide items.
  always_comb begin
    out_valid_nxt = adv ? d2_vld : out_valid_r;
    if (d2_pipe.sel == fpa_pkg::SEL_DIV) begin
      out_data_nxt = dv_res;
    end else begin
      out_data_nxt = d2_pipe.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/fpa_delay.sv -----
module fpa_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_r [DEPTH];
  logic [DEPTH-1:0] vld_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic         vld_nxt;
    logic [W-1:0] data_nxt;

    if (k == 0) begin : g_first
      assign vld_nxt  = vld_i;
      assign data_nxt = data_i;
    end else begin : g_next
      assign vld_nxt  = vld_r[k-1];
      assign data_nxt = data_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        data_r[k] <= data_nxt;
      end
    end
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign data_o = data_r[DEPTH-1];

endmodule

// ----- src/fpa_front.sv -----
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  fpa_pkg::in_item_t                in_item,
  output logic                             vld_o,
  output fpa_pkg::pipe_t                   pipe_o,
  output logic signed [fpa_pkg::DATA_W-1:0] a_o,
  output logic signed [fpa_pkg::DATA_W-1:0] b_o,
  output fpa_pkg::div_in_t                 div_o
);

  localparam int DW = fpa_pkg::DATA_W;

  // Clamps a wide signed value to the data range; the top bit flags a clamp.
  function automatic logic [DW:0] clamp_dw(input logic signed [2*DW-1:0] v);
    logic signed [2*DW-1:0] hi;
    logic signed [2*DW-1:0] lo;
    hi = {{DW{fpa_pkg::S32_MAX[DW-1]}}, fpa_pkg::S32_MAX};
    lo = {{DW{fpa_pkg::S32_MIN[DW-1]}}, fpa_pkg::S32_MIN};
    if (v > hi) begin
      clamp_dw = {1'b1, fpa_pkg::S32_MAX};
    end else if (v < lo) begin
      clamp_dw = {1'b1, fpa_pkg::S32_MIN};
    end else begin
      clamp_dw = {1'b0, v[DW-1:0]};
    end
  endfunction

  logic                       vld_r;
  fpa_pkg::pipe_t             pipe_r, pipe_nxt;
  logic signed [DW-1:0]       a_r, b_r;
  fpa_pkg::div_in_t           div_r, div_nxt;

  logic signed [DW-1:0]       a, b;
  logic signed [2*DW-1:0]     a_w, b_w;
  logic [DW:0]                cl;

  always_comb begin
    a   = in_item.operand_a;
    b   = in_item.operand_b;
    a_w = {{DW{a[DW-1]}}, a};
    b_w = {{DW{b[DW-1]}}, b};
    cl  = '0;

    pipe_nxt.sel                = fpa_pkg::SEL_SIMPLE;
    pipe_nxt.res.result         = '0;
    pipe_nxt.res.compare_true   = 1'b0;
    pipe_nxt.res.saturated      = 1'b0;
    pipe_nxt.res.divide_by_zero = 1'b0;

    case (fpa_pkg::op_t'(in_item.op))
      fpa_pkg::OP_ADD: cl = clamp_dw(a_w + b_w);
      fpa_pkg::OP_SUB: cl = clamp_dw(a_w - b_w);
      fpa_pkg::OP_MUL: pipe_nxt.sel = fpa_pkg::SEL_MUL;
      fpa_pkg::OP_DIV: pipe_nxt.sel = fpa_pkg::SEL_DIV;
      fpa_pkg::OP_MIN: cl = {1'b0, (a > b) ? b : a};
      fpa_pkg::OP_MAX: cl = {1'b0, (b > a) ? b : a};
      fpa_pkg::OP_INC: cl = clamp_dw(a_w + (2*DW)'(1));
      fpa_pkg::OP_DEC: cl = clamp_dw(a_w - (2*DW)'(1));
      fpa_pkg::OP_TOI: cl = {1'b0, a >>> FRAC_BITS};
      fpa_pkg::OP_FRI: cl = clamp_dw(a_w <<< FRAC_BITS);
      fpa_pkg::OP_EQ:  pipe_nxt.res.compare_true = (a == b);
      fpa_pkg::OP_NE:  pipe_nxt.res.compare_true = (a != b);
      fpa_pkg::OP_LT:  pipe_nxt.res.compare_true = (a < b);
      fpa_pkg::OP_LE:  pipe_nxt.res.compare_true = (a <= b);
      fpa_pkg::OP_GT:  pipe_nxt.res.compare_true = (a > b);
      fpa_pkg::OP_GE:  pipe_nxt.res.compare_true = (a >= b);
      default:         pipe_nxt.res.compare_true = (a >= b);
    endcase

    pipe_nxt.res.result    = cl[DW-1:0];
    pipe_nxt.res.saturated = cl[DW];

    // The magnitude of the most negative value still fits as unsigned.
    div_nxt.na    = a[DW-1] ? (~a + DW'(1)) : a;
    div_nxt.nb    = b[DW-1] ? (~b + DW'(1)) : b;
    div_nxt.neg   = a[DW-1] ^ b[DW-1];
    div_nxt.a_neg = a[DW-1];
    div_nxt.dz    = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
      a_r    <= a;
      b_r    <= b;
      div_r  <= div_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign pipe_o = pipe_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign div_o  = div_r;

endmodule

// ----- src/fpa_mul.sv -----
module fpa_mul #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fpa_pkg::DATA_W-1:0] a_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] b_i,
  output fpa_pkg::out_item_t                res_o
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam logic [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (DW - 1);
  localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

  logic signed [PW-1:0] p_r;
  logic [PW-1:0]        m_r, r_r, m_nxt, r_nxt;
  logic                 neg_m_r, neg_r_r;
  fpa_pkg::out_item_t   res_r, res_nxt;

  always_comb begin
    m_nxt = p_r[PW-1] ? (~p_r + PW'(1)) : p_r;
    r_nxt = (m_r + HALF) >> FRAC_BITS;

    res_nxt.compare_true   = 1'b0;
    res_nxt.divide_by_zero = 1'b0;
    res_nxt.saturated      = neg_r_r ? (r_r > LIM_NEG) : (r_r > LIM_POS);
    if (res_nxt.saturated) begin
      res_nxt.result = neg_r_r ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
    end else if (neg_r_r) begin
      res_nxt.result = ~r_r[DW-1:0] + DW'(1);
    end else begin
      res_nxt.result = r_r[DW-1:0];
    end
  end

  // Product, magnitude, rounding and clamp each have a stage of their own.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= a_i * b_i;
      m_r     <= m_nxt;
      neg_m_r <= p_r[PW-1];
      r_r     <= r_nxt;
      neg_r_r <= neg_m_r;
      res_r   <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ----- src/fpa_div.sv -----
module fpa_div #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  fpa_pkg::div_in_t   div_i,
  output fpa_pkg::out_item_t res_o
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int QB = fpa_pkg::DIV_QBITS;
  localparam int CW = QB + DW;
  localparam logic [QB:0] LIM_NEG = (QB+1)'(1) << (DW - 1);
  localparam logic [QB:0] LIM_POS = LIM_NEG - (QB+1)'(1);

  // Index 0 is the set-up stage, index k+1 holds the state after quotient
  // bit QB-1-k has been decided.
  logic [CW-1:0]     rem_r [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic [DW-1:0]     d_r   [QB+1];
  fpa_pkg::div_ctl_t ctl_r [QB+1];

  logic [CW-1:0]     num;
  logic [CW-1:0]     d_top;
  fpa_pkg::div_ctl_t ctl_nxt;

  always_comb begin
    num           = CW'(div_i.na) << FRAC_BITS;
    d_top         = CW'(div_i.nb) << QB;
    ctl_nxt.neg   = div_i.neg;
    ctl_nxt.a_neg = div_i.a_neg;
    ctl_nxt.dz    = div_i.dz;
    // A quotient that does not fit in QB bits saturates in any case.
    ctl_nxt.ovf   = (num >= d_top);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      d_r[0]   <= div_i.nb;
      ctl_r[0] <= ctl_nxt;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW-1:0] trial;
    logic          fit;

    assign trial = CW'(d_r[k]) << (QB - 1 - k);
    assign fit   = (rem_r[k] >= trial);

    // The bit decided here is still clear in q_r[k], so it is simply ORed in.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= fit ? (rem_r[k] - trial) : rem_r[k];
        q_r[k+1]   <= q_r[k] | (QB'(fit) << (QB - 1 - k));
        d_r[k+1]   <= d_r[k];
        ctl_r[k+1] <= ctl_r[k];
      end
    end
  end

  // Rounding: round up when twice the remainder reaches the divisor.
  logic [QB:0]        qr_r, qr_nxt;
  fpa_pkg::div_ctl_t  ctl_rd_r;
  logic               up;
  fpa_pkg::out_item_t res_r, res_nxt;

  always_comb begin
    up     = ({rem_r[QB][DW-1:0], 1'b0} >= {1'b0, d_r[QB]});
    qr_nxt = {1'b0, q_r[QB]} + (QB+1)'(up);
  end

  always_comb begin
    res_nxt.compare_true   = 1'b0;
    res_nxt.divide_by_zero = ctl_rd_r.dz;
    if (ctl_rd_r.dz) begin
      res_nxt.saturated = 1'b1;
      res_nxt.result    = ctl_rd_r.a_neg ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
    end else if (ctl_rd_r.ovf || (ctl_rd_r.neg ? (qr_r > LIM_NEG) : (qr_r > LIM_POS))) begin
      res_nxt.saturated = 1'b1;
      res_nxt.result    = ctl_rd_r.neg ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
    end else begin
      res_nxt.saturated = 1'b0;
      res_nxt.result    = ctl_rd_r.neg ? (~qr_r[DW-1:0] + DW'(1)) : qr_r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r     <= qr_nxt;
      ctl_rd_r <= ctl_r[QB];
      res_r    <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ----- verif/fixed_point_alu_unit_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the fixed-point ALU and predicts each result.
// Results are compared field by field against the oldest outstanding one.
module fixed_point_alu_unit_checker
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        results_seen
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct {
    in_item_t  stim;
    out_item_t want;
  } alu_txn_t;

  alu_txn_t results_due[$];
  alu_txn_t oldest;
  int       mismatches = 0;
  int       checked = 0;

  // Exact fixed-point arithmetic on 64-bit intermediates, clamped at the end.
  function automatic out_item_t fixed_alu_result(input in_item_t it);
    longint      a;
    longint      b;
    longint      wide;
    longint      prod;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    out_item_t   r;
    a    = {{32{it.operand_a[31]}}, it.operand_a};
    b    = {{32{it.operand_b[31]}}, it.operand_b};
    r    = '0;
    wide = 0;
    case (op_t'(it.op))
      OP_ADD: wide = a + b;
      OP_SUB: wide = a - b;
      OP_MUL: begin
        prod = a * b;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        wide = (prod < 0) ? -$signed(mag) : $signed(mag);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
          r.saturated      = 1'b1;
          wide             = (a < 0) ? WORD_MIN : WORD_MAX;
        end else begin
          num = (a < 0) ? -a : a;
          num = num << FRAC_BITS;
          den = (b < 0) ? -b : b;
          quo = num / den;
          rem = num % den;
          if (rem >= den - rem) quo = quo + 1;
          wide = ((a < 0) != (b < 0)) ? -$signed(quo) : $signed(quo);
        end
      end
      OP_MIN: wide = (a > b) ? b : a;
      OP_MAX: wide = (b > a) ? b : a;
      OP_INC: wide = a + 1;
      OP_DEC: wide = a - 1;
      OP_TOI: wide = a >>> FRAC_BITS;
      OP_FRI: wide = a <<< FRAC_BITS;
      OP_EQ:  r.compare_true = (a == b);
      OP_NE:  r.compare_true = (a != b);
      OP_LT:  r.compare_true = (a < b);
      OP_LE:  r.compare_true = (a <= b);
      OP_GT:  r.compare_true = (a > b);
      OP_GE:  r.compare_true = (a >= b);
    endcase
    if (wide > WORD_MAX) begin
      wide        = WORD_MAX;
      r.saturated = 1'b1;
    end else if (wide < WORD_MIN) begin
      wide        = WORD_MIN;
      r.saturated = 1'b1;
    end
    r.result = wide[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing outstanding: result %0d",
                     $realtime, out_data.result);
        end else begin
          oldest = results_due.pop_front();
          checked++;
          if (out_data.result !== oldest.want.result ||
              out_data.compare_true !== oldest.want.compare_true ||
              out_data.saturated !== oldest.want.saturated ||
              out_data.divide_by_zero !== oldest.want.divide_by_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: op %0d a %0d b %0d: expected %0d cmp %b sat %b dz %b, got %0d cmp %b sat %b dz %b",
                       $realtime, oldest.stim.op, oldest.stim.operand_a,
                       oldest.stim.operand_b, oldest.want.result,
                       oldest.want.compare_true, oldest.want.saturated,
                       oldest.want.divide_by_zero, out_data.result,
                       out_data.compare_true, out_data.saturated,
                       out_data.divide_by_zero);
          end
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back('{stim: in_data, want: fixed_alu_result(in_data)});
    end
    pending      <= results_due.size();
    fail_count   <= mismatches;
    results_seen <= checked;
  end

endmodule

// ----- verif/fixed_point_alu_unit_tb.sv -----
`timescale 1ns / 100ps

// Top of the fixed-point ALU testbench. It produces the stimulus, drives the
// receiver's stall and gives the verdict; prediction and comparison live in
// the checker, which sits beside the block and watches both channels.
module fixed_point_alu_unit_tb;
  import fpa_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  // This margin covers the block's whole path with room left.
  localparam int DRAIN_CYCLES = 48;
  // Items, counted from the start, after which the receiver holds off.
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent = 0;

  // While steady is set neither side idles, so the pipeline runs flat out.
  bit steady = 1'b0;
  bit held_off = 1'b0;

  fixed_point_alu_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fixed_point_alu_unit_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hung handshake must not keep the simulation alive for ever.
  initial begin
    #1000000;
    $display("fixed_point_alu_unit test failed");
    $finish;
  end

  function automatic in_item_t mk_item(input op_t op, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    in_item_t it;
    it.op        = op;
    it.operand_a = a;
    it.operand_b = b;
    return it;
  endfunction

  // Operands come in three flavours: the corner values, fully random words,
  // and random words scaled down by an arithmetic shift, so that products,
  // quotients and conversions land in range as well as out of it.
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = S32_MAX;
          1:       v = S32_MIN;
          2:       v = '0;
          3:       v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: ;
      default: v = v >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  // Offers one item and holds it steady until the transfer takes place.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // The sender drops valid for whole cycles, about a quarter of the time.
  task automatic maybe_idle();
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Receiver: random stalls on about a quarter of the cycles, none at all in
  // the steady stretch, and one long hold-off while the sender keeps offering
  // items, so that the pipeline fills and the block stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (steady) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 25);
    end
  end

  initial begin
    in_item_t           it;
    logic signed [31:0] a;
    logic signed [31:0] b;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: saturation at both ends, rounding of halves away from
    // zero, division by zero for each sign of the dividend, the conversions
    // and every compare.
    send_item(mk_item(OP_ADD, S32_MAX, 32'sd1));
    send_item(mk_item(OP_ADD, S32_MIN, -32'sd1));
    send_item(mk_item(OP_SUB, S32_MIN, 32'sd1));
    send_item(mk_item(OP_MUL, S32_MAX, S32_MAX));
    send_item(mk_item(OP_MUL, S32_MIN, S32_MIN));
    send_item(mk_item(OP_MUL, 32'sd1, 32'sd128));
    send_item(mk_item(OP_MUL, -32'sd1, 32'sd128));
    send_item(mk_item(OP_DIV, 32'sd5, 32'sd0));
    send_item(mk_item(OP_DIV, 32'sd0, 32'sd0));
    send_item(mk_item(OP_DIV, -32'sd5, 32'sd0));
    send_item(mk_item(OP_DIV, S32_MIN, -32'sd1));
    send_item(mk_item(OP_DIV, 32'sd1, 32'sd512));
    send_item(mk_item(OP_DIV, -32'sd1, 32'sd512));
    send_item(mk_item(OP_MIN, S32_MIN, S32_MAX));
    send_item(mk_item(OP_MAX, 32'sd7, 32'sd7));
    send_item(mk_item(OP_INC, S32_MAX, 32'sd0));
    send_item(mk_item(OP_DEC, S32_MIN, -32'sd1));
    send_item(mk_item(OP_TOI, S32_MIN, 32'sd0));
    send_item(mk_item(OP_TOI, -32'sd1, 32'sd0));
    send_item(mk_item(OP_FRI, S32_MAX, 32'sd0));
    send_item(mk_item(OP_FRI, -32'sd1, 32'sd0));
    send_item(mk_item(OP_EQ, -32'sd1, -32'sd1));
    send_item(mk_item(OP_NE, 32'sd0, S32_MIN));
    send_item(mk_item(OP_LT, S32_MIN, S32_MAX));
    send_item(mk_item(OP_LE, S32_MAX, S32_MIN));
    send_item(mk_item(OP_GT, 32'sd0, -32'sd1));
    send_item(mk_item(OP_GE, S32_MAX, S32_MAX));

    // Random items. Now and then the operands are made equal, which matters
    // for min, max and the compares.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 900 && i < 1250);
      a = pick_operand();
      b = ($urandom_range(7) == 0) ? a : pick_operand();
      it = mk_item(op_t'($urandom_range(15)), a, b);
      maybe_idle();
      send_item(it);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Let the checker register the last transfer, then drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items over all sixteen operations, %0d results compared.",
             items_sent, results_seen);
    $display("Covered saturation, rounding, zero divisors, a long back-pressure hold and a burst without gaps.");
    if (fail_count == 0 && pending == 0) begin
      $display("fixed_point_alu_unit test passed");
    end else begin
      $display("fixed_point_alu_unit test failed");
    end
    $finish;
  end

endmodule
